/* hw/rtl/sbfc_pkg.sv */
`default_nettype none
package sbfc_pkg;

  localparam int ADDR_W  = 33;
  localparam int TOTAL_W = 32;
  localparam int LIMIT_W = 19;
  localparam int CRC_W   = 32;
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;

  localparam logic [CRC_W-1:0]   CRC_SEED      = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY      = 32'hEDB8_8320;
  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 19'h40000;

  localparam logic [WORD_W-1:0] VER_MAJOR = 32'd3;
  localparam logic [WORD_W-1:0] VER_MINOR = 32'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic JOB_START = 1'b0;
  localparam logic JOB_DATA  = 1'b1;

  localparam int HDR_BYTES = 16;
  localparam int IDX_W     = 6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  base;
    logic [BYTE_W-1:0]  data;
    logic               patch;
    logic [LIMIT_W-1:0] size;
    logic [CRC_W-1:0]   crc;
    logic               done;
  } job_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int j = 0; j < BYTE_W; j++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/stored_block_framer_crc32_top.sv */
// Stored-block container framer: a start transaction (cmd 0) emits the 16-byte
// file header, and 16 more bytes for an empty block when total_length is 0;
// each data transaction (cmd 1) emits one addressed byte write, plus a 16-byte
// block header patch (flags, size twice, reflected CRC-32) when the block fills
// or the stream ends. Inputs are taken one per cycle into a 4-entry job queue
// while it is not full; results leave a single output sequencer one write per
// cycle while popped; a data byte is 1 write, block-closing 17, start 16 or 32.
// The sequencer sets the sustained rate, and the queue absorbs header bursts.
// Data while no stream is open is accepted and produces nothing.
`default_nettype none
module stored_block_framer_crc32_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         in_cmd,
  input  wire logic [sbfc_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [sbfc_pkg::ADDR_W-1:0]       out_addr,
  output logic [sbfc_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_run_last,
  output logic                              out_stream_done,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_idx,
  input  wire logic [sbfc_pkg::TOTAL_W-1:0] cfg_wdata
);

  logic           q_push;
  logic           q_pop;
  logic           q_vld;
  logic           q_full;
  sbfc_pkg::job_t wr_job;
  sbfc_pkg::job_t rd_job;

  assign full = q_full;

  sbfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (wr_job)
  );

  sbfc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_job (wr_job),
    .rd_en  (q_pop),
    .rd_job (rd_job),
    .q_vld  (q_vld),
    .q_full (q_full)
  );

  sbfc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_job           (rd_job),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_addr        (out_addr),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

`ifndef NO_ASSERTIONS
  a_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_cmd == sbfc_pkg::CMD_START) |=> q_vld)
    else $error("start transaction not queued");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_stream_done) |-> out_run_last)
    else $error("stream end not on last write of its transaction");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("job taken from empty queue");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sbfc_front.sv */
`default_nettype none
module sbfc_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire logic                            in_cmd,
  input  wire logic [sbfc_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_idx,
  input  wire logic [sbfc_pkg::TOTAL_W-1:0]    cfg_wdata,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output sbfc_pkg::job_t                       q_job
);

  logic [sbfc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [sbfc_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [sbfc_pkg::CRC_W-1:0]   crc_r, crc_nxt;
  logic [sbfc_pkg::LIMIT_W-1:0] fill_r, fill_nxt;
  logic [sbfc_pkg::TOTAL_W-1:0] cons_r, cons_nxt;
  logic [sbfc_pkg::ADDR_W-1:0]  wofs_r, wofs_nxt;
  logic [sbfc_pkg::ADDR_W-1:0]  hofs_r, hofs_nxt;
  logic                         open_r, open_nxt;

  logic                         accept;
  logic [sbfc_pkg::LIMIT_W-1:0] lim;
  logic                         new_blk;
  logic [sbfc_pkg::ADDR_W-1:0]  hofs_d;
  logic [sbfc_pkg::ADDR_W-1:0]  waddr;
  logic [sbfc_pkg::ADDR_W-1:0]  wofs_inc;
  logic [sbfc_pkg::CRC_W-1:0]   crc_d;
  logic [sbfc_pkg::LIMIT_W-1:0] fill_d;
  logic [sbfc_pkg::TOTAL_W-1:0] cons_d;
  logic                         done_d;
  logic                         close_d;
  logic                         empty_strm;

  assign accept = push && !q_full;

  always_comb begin
    lim        = (limit_r == '0) ? sbfc_pkg::LIMIT_W'(1) : limit_r;
    new_blk    = (fill_r == '0);
    hofs_d     = new_blk ? wofs_r : hofs_r;
    waddr      = wofs_r + (new_blk ? sbfc_pkg::ADDR_W'(16) : '0);
    wofs_inc   = wofs_r + (new_blk ? sbfc_pkg::ADDR_W'(17) : sbfc_pkg::ADDR_W'(1));
    crc_d      = sbfc_pkg::crc_byte(crc_r, in_data_byte);
    fill_d     = fill_r + sbfc_pkg::LIMIT_W'(1);
    cons_d     = cons_r + sbfc_pkg::TOTAL_W'(1);
    done_d     = (cons_d >= total_r);
    close_d    = done_d || (fill_d >= lim);
    empty_strm = (total_r == '0);

    total_nxt = total_r;
    limit_nxt = limit_r;
    if (cfg_we && cfg_idx == sbfc_pkg::REG_TOTAL) begin
      total_nxt = cfg_wdata;
    end
    if (cfg_we && cfg_idx == sbfc_pkg::REG_LIMIT) begin
      limit_nxt = cfg_wdata[sbfc_pkg::LIMIT_W-1:0];
    end

    crc_nxt  = crc_r;
    fill_nxt = fill_r;
    cons_nxt = cons_r;
    wofs_nxt = wofs_r;
    hofs_nxt = hofs_r;
    open_nxt = open_r;
    q_push   = 1'b0;
    q_job    = '0;

    if (accept) begin
      if (in_cmd == sbfc_pkg::CMD_START) begin
        q_push     = 1'b1;
        q_job.kind = sbfc_pkg::JOB_START;
        q_job.size = lim;
        q_job.crc  = total_r;
        q_job.done = empty_strm;
        crc_nxt    = sbfc_pkg::CRC_SEED;
        fill_nxt   = '0;
        cons_nxt   = '0;
        hofs_nxt   = sbfc_pkg::ADDR_W'(16);
        wofs_nxt   = empty_strm ? sbfc_pkg::ADDR_W'(32) : sbfc_pkg::ADDR_W'(16);
        open_nxt   = !empty_strm;
      end else if (open_r) begin
        q_push      = 1'b1;
        q_job.kind  = sbfc_pkg::JOB_DATA;
        q_job.addr  = waddr;
        q_job.base  = hofs_d;
        q_job.data  = in_data_byte;
        q_job.patch = close_d;
        q_job.size  = fill_d;
        q_job.crc   = crc_d;
        q_job.done  = done_d;
        hofs_nxt    = hofs_d;
        wofs_nxt    = wofs_inc;
        cons_nxt    = cons_d;
        crc_nxt     = close_d ? sbfc_pkg::CRC_SEED : crc_d;
        fill_nxt    = close_d ? '0 : fill_d;
        if (done_d) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      limit_r <= sbfc_pkg::LIMIT_DEFAULT;
      crc_r   <= sbfc_pkg::CRC_SEED;
      fill_r  <= '0;
      cons_r  <= '0;
      wofs_r  <= '0;
      hofs_r  <= '0;
      open_r  <= 1'b0;
    end else begin
      total_r <= total_nxt;
      limit_r <= limit_nxt;
      crc_r   <= crc_nxt;
      fill_r  <= fill_nxt;
      cons_r  <= cons_nxt;
      wofs_r  <= wofs_nxt;
      hofs_r  <= hofs_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sbfc_queue.sv */
`default_nettype none
module sbfc_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  sbfc_pkg::job_t wr_job,
  input  wire logic     rd_en,
  output sbfc_pkg::job_t rd_job,
  output logic          q_vld,
  output logic          q_full
);

  sbfc_pkg::job_t                mem_r [sbfc_pkg::QDEPTH];
  logic [sbfc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sbfc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sbfc_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_wr;
  logic                          do_rd;

  assign q_vld  = (cnt_r != '0);
  assign q_full = (cnt_r == sbfc_pkg::QCNT_W'(sbfc_pkg::QDEPTH));
  assign rd_job = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !q_full;
  assign do_rd  = rd_en && q_vld;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + sbfc_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + sbfc_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + sbfc_pkg::QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - sbfc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sbfc_back.sv */
`default_nettype none
module sbfc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_vld,
  input  sbfc_pkg::job_t                    q_job,
  output logic                              q_pop,
  input  wire logic                         pop,
  output logic                              empty,
  output logic [sbfc_pkg::ADDR_W-1:0]       out_addr,
  output logic [sbfc_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_run_last,
  output logic                              out_stream_done
);

  localparam logic [sbfc_pkg::IDX_W-1:0] LAST_DATA  = sbfc_pkg::IDX_W'(0);
  localparam logic [sbfc_pkg::IDX_W-1:0] LAST_PATCH = sbfc_pkg::IDX_W'(sbfc_pkg::HDR_BYTES);
  localparam logic [sbfc_pkg::IDX_W-1:0] LAST_HDR   = sbfc_pkg::IDX_W'(sbfc_pkg::HDR_BYTES - 1);
  localparam logic [sbfc_pkg::IDX_W-1:0] LAST_EMPTY =
    sbfc_pkg::IDX_W'(2 * sbfc_pkg::HDR_BYTES - 1);

  sbfc_pkg::job_t                 cur_r, cur_nxt;
  logic                           cur_vld_r, cur_vld_nxt;
  logic [sbfc_pkg::IDX_W-1:0]     idx_r, idx_nxt;

  logic                           out_vld_r, out_vld_nxt;
  logic [sbfc_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [sbfc_pkg::BYTE_W-1:0]    byte_r, byte_nxt;
  logic                           last_r, last_nxt;
  logic                           sdone_r, sdone_nxt;

  logic                           adv;
  logic                           is_last;
  logic [3:0]                     hb;
  logic [sbfc_pkg::WORD_W-1:0]    word;
  logic [sbfc_pkg::WORD_W-1:0]    size_w;

  assign adv   = cur_vld_r && (!out_vld_r || pop);
  assign q_pop = q_vld && (!cur_vld_r || (adv && is_last));

  always_comb begin
    size_w = {{(sbfc_pkg::WORD_W-sbfc_pkg::LIMIT_W){1'b0}}, cur_r.size};
    word   = '0;
    if (cur_r.kind == sbfc_pkg::JOB_START) begin
      hb      = idx_r[3:0];
      is_last = cur_r.done ? (idx_r == LAST_EMPTY) : (idx_r == LAST_HDR);
      if (!idx_r[4]) begin
        unique case (hb[3:2])
          2'd0: word = sbfc_pkg::VER_MAJOR;
          2'd1: word = sbfc_pkg::VER_MINOR;
          2'd2: word = size_w;
          2'd3: word = cur_r.crc;
          default: word = '0;
        endcase
      end else begin
        word = (hb[3:2] == 2'd3) ? sbfc_pkg::CRC_SEED : '0;
      end
      addr_nxt = {{(sbfc_pkg::ADDR_W-sbfc_pkg::IDX_W){1'b0}}, idx_r};
      byte_nxt = word[8*hb[1:0] +: 8];
    end else begin
      hb      = 4'(idx_r - sbfc_pkg::IDX_W'(1));
      is_last = cur_r.patch ? (idx_r == LAST_PATCH) : (idx_r == LAST_DATA);
      unique case (hb[3:2])
        2'd0: word = '0;
        2'd1: word = size_w;
        2'd2: word = size_w;
        2'd3: word = cur_r.crc;
        default: word = '0;
      endcase
      if (idx_r == LAST_DATA) begin
        addr_nxt = cur_r.addr;
        byte_nxt = cur_r.data;
      end else begin
        addr_nxt = cur_r.base + {{(sbfc_pkg::ADDR_W-4){1'b0}}, hb};
        byte_nxt = word[8*hb[1:0] +: 8];
      end
    end
    last_nxt  = is_last;
    sdone_nxt = is_last && cur_r.done;

    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (!cur_vld_r || (adv && is_last)) begin
      cur_nxt     = q_job;
      cur_vld_nxt = q_vld;
      idx_nxt     = '0;
    end else if (adv) begin
      idx_nxt = idx_r + sbfc_pkg::IDX_W'(1);
    end

    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv) begin
      addr_r  <= addr_nxt;
      byte_r  <= byte_nxt;
      last_r  <= last_nxt;
      sdone_r <= sdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign empty           = !out_vld_r;
  assign out_addr        = addr_r;
  assign out_byte        = byte_r;
  assign out_run_last    = last_r;
  assign out_stream_done = sdone_r;

endmodule
`default_nettype wire
